// ----- rtl/cdue_pkg.sv -----
// ----------------------------------------------------------------------------
// cdue_pkg
// Shared widths, constants, stage payload types and the day-of-year table
// for the civil date to Unix epoch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cdue_pkg;

  // Field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int EPOCH_W  = 32;

  // Internal widths
  localparam int K_W    = 8;   // March-based year minus base year, 0..138
  localparam int DOY_W  = 9;   // day of March-based year, 0..367
  localparam int TOD_W  = 17;  // seconds within the day, before range check
  localparam int DAYS_W = 16;  // days since 1970-01-01, up to about 50100
  localparam int SECS_W = 33;  // one bit above the 32-bit result

  // Calendar limits
  localparam int YEAR_MIN   = 1970;
  localparam int YEAR_LATE  = 2107;  // from here on every moment is past 2^32-1 s
  localparam int BASE_YEAR  = 1968;
  localparam int MONTH_MIN  = 1;
  localparam int MONTH_MAX  = 12;
  localparam int MONTH_FEB  = 2;
  localparam int MONTH_MAR  = 3;
  localparam int MONTH_WRAP = 9;
  localparam int HOUR_MAX   = 23;
  localparam int MINUTE_MAX = 59;
  localparam int SECOND_MAX = 60;

  // Day arithmetic relative to the 1968 base year
  localparam int DAYS_PER_YEAR = 365;
  localparam int CENTURY_K     = 132;  // March-based year 2100, not a leap year
  localparam int DAY_BIAS      = 671;  // shifts the count so 1970-01-01 is day 0

  localparam int SECS_PER_DAY    = 86400;
  localparam int SECS_PER_HOUR   = 3600;
  localparam int SECS_PER_MINUTE = 60;

  // Decode stage payload
  typedef struct packed {
    logic               ok;
    logic [K_W-1:0]     k;
    logic [DOY_W-1:0]   doy;
    logic [TOD_W-1:0]   tod;
  } dec_t;

  // Day count stage payload
  typedef struct packed {
    logic               ok;
    logic [DAYS_W-1:0]  days;
    logic [TOD_W-1:0]   tod;
  } day_t;

  // Seconds stage payload
  typedef struct packed {
    logic               ok;
    logic [SECS_W-1:0]  secs;
  } sec_t;

  // First day of each month in a March-based year: (153*mp+2)/5
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mp);
    logic [DOY_W-1:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cdue_cal_if.sv -----
// ----------------------------------------------------------------------------
// cdue_cal_if
// Input channel: one calendar date and time per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdue_cal_if import cdue_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   cal_year;
  logic [MONTH_W-1:0]  cal_month;
  logic [DAY_W-1:0]    cal_day;
  logic [HOUR_W-1:0]   cal_hour;
  logic [MINUTE_W-1:0] cal_minute;
  logic [SECOND_W-1:0] cal_second;

  modport source (
    output valid, cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second,
    input  ready
  );

  modport sink (
    input  valid, cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/cdue_epoch_if.sv -----
// ----------------------------------------------------------------------------
// cdue_epoch_if
// Result channel: one epoch value per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdue_epoch_if import cdue_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;
  logic               epoch_valid;

  modport source (
    output valid, epoch_seconds, epoch_valid,
    input  ready
  );

  modport sink (
    input  valid, epoch_seconds, epoch_valid,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/cdue_decode.sv -----
// ----------------------------------------------------------------------------
// cdue_decode
// First stage: range check, March-based year shift, day of year and
// time of day in seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module cdue_decode import cdue_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cdue_cal_if.sink    in_ch,
  output logic        dn_valid,
  input  wire logic   dn_ready,
  output dec_t        dn_data
);

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  dec_t               s1_r;
  dec_t               s1_nxt;
  logic               take;
  logic               early;
  logic [YEAR_W-1:0]  yshift;
  logic [MONTH_W-1:0] mp;

  assign in_ch.ready = !s1_valid_r || dn_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    early  = (in_ch.cal_month <= MONTH_W'(MONTH_FEB));
    yshift = in_ch.cal_year - YEAR_W'(early);
    mp     = early ? in_ch.cal_month + MONTH_W'(MONTH_WRAP)
                   : in_ch.cal_month - MONTH_W'(MONTH_MAR);

    s1_nxt.ok = (in_ch.cal_year >= YEAR_W'(YEAR_MIN)) &&
                (in_ch.cal_year < YEAR_W'(YEAR_LATE)) &&
                (in_ch.cal_month >= MONTH_W'(MONTH_MIN)) &&
                (in_ch.cal_month <= MONTH_W'(MONTH_MAX)) &&
                (in_ch.cal_day != '0) &&
                (in_ch.cal_hour <= HOUR_W'(HOUR_MAX)) &&
                (in_ch.cal_minute <= MINUTE_W'(MINUTE_MAX)) &&
                (in_ch.cal_second <= SECOND_W'(SECOND_MAX));

    // Zero the day fields of a rejected beat so later stages stay in range
    if (s1_nxt.ok) begin
      s1_nxt.k   = K_W'(yshift - YEAR_W'(BASE_YEAR));
      s1_nxt.doy = month_start(mp) + DOY_W'(in_ch.cal_day) - DOY_W'(1);
    end else begin
      s1_nxt.k   = '0;
      s1_nxt.doy = '0;
    end

    s1_nxt.tod = TOD_W'(in_ch.cal_hour) * TOD_W'(SECS_PER_HOUR) +
                 TOD_W'(in_ch.cal_minute) * TOD_W'(SECS_PER_MINUTE) +
                 TOD_W'(in_ch.cal_second);

    s1_valid_nxt = take ? 1'b1 : (dn_ready ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r <= s1_nxt;
    end
  end

  assign dn_valid = s1_valid_r;
  assign dn_data  = s1_r;

endmodule

`default_nettype wire

// ----- rtl/cdue_accum.sv -----
// ----------------------------------------------------------------------------
// cdue_accum
// Second and third stages: day count since 1970-01-01, then scale to
// seconds and add the time of day.
// ----------------------------------------------------------------------------
`default_nettype none

module cdue_accum import cdue_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   up_valid,
  output logic        up_ready,
  input  wire dec_t   up_data,
  output logic        dn_valid,
  input  wire logic   dn_ready,
  output sec_t        dn_data
);

  logic              s2_valid_r;
  logic              s2_valid_nxt;
  day_t              s2_r;
  day_t              s2_nxt;
  logic              s3_valid_r;
  logic              s3_valid_nxt;
  sec_t              s3_r;
  sec_t              s3_nxt;
  logic              s3_in_ready;
  logic              take2;
  logic              take3;
  logic [DAYS_W:0]   days_sum;

  assign s3_in_ready = !s3_valid_r || dn_ready;
  assign up_ready    = !s2_valid_r || s3_in_ready;
  assign take2       = up_valid && up_ready;
  assign take3       = s2_valid_r && s3_in_ready;

  always_comb begin
    // 365 per year, one leap day every fourth year, drop the one for 2100
    days_sum = (DAYS_W+1)'(up_data.k) * (DAYS_W+1)'(DAYS_PER_YEAR) +
               (DAYS_W+1)'(up_data.k >> 2) +
               (DAYS_W+1)'(up_data.doy) -
               (DAYS_W+1)'(DAY_BIAS) -
               (DAYS_W+1)'(up_data.k >= K_W'(CENTURY_K));
    s2_nxt.ok   = up_data.ok;
    s2_nxt.days = up_data.ok ? days_sum[DAYS_W-1:0] : '0;
    s2_nxt.tod  = up_data.tod;

    s3_nxt.ok   = s2_r.ok;
    s3_nxt.secs = SECS_W'(s2_r.days) * SECS_W'(SECS_PER_DAY) + SECS_W'(s2_r.tod);

    s2_valid_nxt = take2 ? 1'b1 : (s3_in_ready ? 1'b0 : s2_valid_r);
    s3_valid_nxt = take3 ? 1'b1 : (dn_ready ? 1'b0 : s3_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take2) begin
      s2_r <= s2_nxt;
    end
    if (take3) begin
      s3_r <= s3_nxt;
    end
  end

  assign dn_valid = s3_valid_r;
  assign dn_data  = s3_r;

endmodule

`default_nettype wire

// ----- rtl/civil_date_to_unix_epoch_unit.sv -----
// ----------------------------------------------------------------------------
// civil_date_to_unix_epoch_unit
// Converts a UTC calendar date and time to 32-bit Unix epoch seconds.
// ----------------------------------------------------------------------------
// Four register stages, one beat in and one beat out per cycle at full rate;
// each result passes decode, days, seconds and output in turn. The depth is
// set by the constant multiplies: days to seconds (16 x 17 bits) sits alone
// in its stage. Every stage has its own valid bit and takes a new beat when
// it is empty or its successor moves, so a stall on the output only backs up
// as far as it must and nothing is lost or repeated. A date with a field out
// of range, a year below 1970, exactly the epoch, or a moment past 2^32-1 s
// returns epoch_seconds 0 with epoch_valid low. The day is not checked
// against the month length: an excess day rolls into the next month.
// ----------------------------------------------------------------------------
`default_nettype none

module civil_date_to_unix_epoch_unit import cdue_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  cdue_cal_if.sink     in_ch,
  cdue_epoch_if.source out_ch
);

  logic               dec_valid;
  logic               dec_ready;
  dec_t               dec_data;
  logic               acc_valid;
  logic               acc_ready;
  sec_t               acc_data;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [EPOCH_W-1:0] out_epoch_r;
  logic [EPOCH_W-1:0] out_epoch_nxt;
  logic               out_flag_r;
  logic               out_flag_nxt;
  logic               take4;

  // Stage 1: check and decode
  cdue_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (dec_valid),
    .dn_ready (dec_ready),
    .dn_data  (dec_data)
  );

  // Stages 2 and 3: days, then seconds
  cdue_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (acc_valid),
    .dn_ready (acc_ready),
    .dn_data  (acc_data)
  );

  // Stage 4: zero anything rejected or overflowed past 32 bits, then hold for the sink
  assign acc_ready = !out_valid_r || out_ch.ready;
  assign take4     = acc_valid && acc_ready;

  always_comb begin
    out_epoch_nxt = (acc_data.ok && !acc_data.secs[SECS_W-1]) ?
                    acc_data.secs[EPOCH_W-1:0] : '0;
    out_flag_nxt  = (out_epoch_nxt != '0);
    out_valid_nxt = take4 ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take4) begin
      out_epoch_r <= out_epoch_nxt;
      out_flag_r  <= out_flag_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.epoch_seconds = out_epoch_r;
  assign out_ch.epoch_valid   = out_flag_r;

  // The flag must agree with the value it qualifies
  a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.epoch_valid == (out_ch.epoch_seconds != '0)))
    else $error("epoch_valid disagrees with epoch_seconds");

  // A beat leaving stage 3 lands in the output register
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_valid && acc_ready) |=> out_valid_r)
    else $error("stage 3 beat lost on its way to the output");

  // A rejected beat never shows a nonzero value
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (take4 && !acc_data.ok) |=> (out_epoch_r == '0))
    else $error("rejected beat produced a nonzero epoch");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
